### rtl/pris_pkg.sv
package pris_pkg;

   // line buffer depth, copy cap and row limit
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_COPIES = 63;
   localparam int ROWS_LIMIT = 4096;

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = $clog2(ROWS_LIMIT);
   localparam int CMP_W = 18;          // compare width for column and row limits
   localparam int PH_W  = 16;          // phase counters, as wide as divisor
   localparam int OC_W  = 19;          // output column and row counters
   localparam int CNT_W = 7;           // results per item, up to MAX_COPIES + 1
   localparam int PIX_W = 24;

   // register indexes of the control port
   typedef enum logic [2:0] {
      REG_IN_WIDTH   = 3'd0,
      REG_IN_HEIGHT  = 3'd1,
      REG_MULTIPLIER = 3'd2,
      REG_DIVISOR    = 3'd3,
      REG_OUT_WIDTH  = 3'd4,
      REG_OUT_HEIGHT = 3'd5
   } reg_index_type;

   // work handed from the state update to the output stage
   typedef struct packed {
      logic              replay;
      logic [PIX_W-1:0]  pix;
      logic [CNT_W-1:0]  count;
      logic              row_end;
      logic [1:0]        pad;
      logic              image_end;
      logic              replay_wanted;
   } job_type;

endpackage

### rtl/pixel_replication_image_scaler.sv
// pixel replication image scaler
// req channel: one item per tvalid/tready handshake; tuser is the command (0 push a pixel,
//   1 replay the next buffered pixel), tdata carries blue, green, red of a pushed pixel
// rsp channel: one result per handshake; tdata holds the pixel bytes and row status,
//   tuser says whether a pixel is carried, tlast marks the final result of an item
// csr port: csr_we writes csr_wdata into the register picked by csr_index at the clock edge;
//   write it only while no item is in flight
// an item updates the counters and touches the line buffer in the cycle it is accepted;
//   its results pass the job stage and the output register and stream out one per cycle while rsp_tready is high
// an item gives n results, n being its result count (up to 64); the single output register
//   and its copy counter send them out in turn
// items with no result, including commands that do not fit the current pass, skip the job stage
// a one-entry job stage between the counters and the output register lets the next item
//   be accepted while the current results still stream
// when rsp_tready is low the output holds, the job stage fills, then req_tready drops
// reset (synchronous, active high) clears all counters and flushes both stages; the line
//   buffer keeps old contents, which are only read after being written for the current row
// req_tready stays low while reset is held
module pixel_replication_image_scaler (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // blue[7:0], green[15:8], red[23:16]
   input  logic        req_tuser,   // cmd
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // blue_out, green_out, red_out, row_end, pad_count[1:0],
                                    // image_end, replay_wanted, zero fill
   output logic        rsp_tuser,   // pixel_valid
   output logic        rsp_tlast,   // last
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [17:0] csr_wdata
);

   localparam int COL_W = pris_pkg::COL_W;
   localparam int ROW_W = pris_pkg::ROW_W;
   localparam int CMP_W = pris_pkg::CMP_W;
   localparam int PH_W  = pris_pkg::PH_W;
   localparam int OC_W  = pris_pkg::OC_W;
   localparam int CNT_W = pris_pkg::CNT_W;
   localparam int PIX_W = pris_pkg::PIX_W;

   // configuration registers
   logic [12:0] cfg_in_width_ff, cfg_in_height_ff;
   logic [5:0]  cfg_mult_ff;
   logic [15:0] cfg_divisor_ff;
   logic [17:0] cfg_out_width_ff, cfg_out_height_ff;

   // scan state
   logic [COL_W-1:0] in_column_ff, in_column_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [PH_W-1:0]  col_phase_ff, col_phase_in;
   logic [PH_W-1:0]  row_phase_ff, row_phase_in;
   logic [OC_W-1:0]  out_column_ff, out_column_in;
   logic [OC_W-1:0]  out_row_ff, out_row_in;
   logic [CNT_W-1:0] rows_left_ff, rows_left_in;
   logic             replaying_ff, replaying_in;

   // line buffer
   logic [PIX_W-1:0] line_mem [pris_pkg::MAX_WIDTH];
   logic [PIX_W-1:0] rdata_ff;

   // job stage
   logic              job_valid_ff;
   pris_pkg::job_type job_ff, job_in;
   logic              job_adv;

   // output register
   logic             out_valid_ff;
   logic [PIX_W-1:0] out_pix_ff;
   logic             out_pvalid_ff;
   logic [CNT_W-1:0] rem_ff;
   logic             out_row_end_ff, out_image_end_ff, out_rw_ff;
   logic [1:0]       out_pad_ff;
   logic             out_last;

   // step logic
   logic             acc, hit, reload, end_col, row_end, image_end;
   logic [5:0]       mult;
   logic [CMP_W-1:0] w_lim, h_lim;
   logic [PH_W-1:0]  col_ph_eff;
   logic [OC_W-1:0]  out_col_eff, room, avail;
   logic [CNT_W-1:0] c_rows, rows_eff, copies, n_pix, n_total, rows_after;

   function automatic logic [PH_W-1:0] next_phase(input logic [PH_W-1:0] ph,
                                                  input logic [15:0] div);
      logic [PH_W:0] inc;
      inc = {1'b0, ph} + (PH_W+1)'(1);
      if (div == '0 || inc >= {1'b0, div}) begin
         return '0;
      end
      return inc[PH_W-1:0];
   endfunction

   // ---------------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_in_width_ff   <= 13'd1;
         cfg_in_height_ff  <= 13'd1;
         cfg_mult_ff       <= 6'd1;
         cfg_divisor_ff    <= '0;
         cfg_out_width_ff  <= 18'd1;
         cfg_out_height_ff <= 18'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            pris_pkg::REG_IN_WIDTH:   cfg_in_width_ff   <= csr_wdata[12:0];
            pris_pkg::REG_IN_HEIGHT:  cfg_in_height_ff  <= csr_wdata[12:0];
            pris_pkg::REG_MULTIPLIER: cfg_mult_ff       <= csr_wdata[5:0];
            pris_pkg::REG_DIVISOR:    cfg_divisor_ff    <= csr_wdata[15:0];
            pris_pkg::REG_OUT_WIDTH:  cfg_out_width_ff  <= csr_wdata;
            pris_pkg::REG_OUT_HEIGHT: cfg_out_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake
   assign job_adv    = job_valid_ff && (!out_valid_ff || (rsp_tready && rem_ff == '0));
   assign req_tready = !reset && (!job_valid_ff || job_adv);
   assign acc        = req_tvalid && req_tready;
   // a command that does not match the current pass is dropped
   assign hit        = acc && (req_tuser == replaying_ff);

   // ---------------------------------------------------------------- step logic
   always_comb begin
      // effective limits
      if (cfg_in_width_ff == '0) begin
         w_lim = CMP_W'(1);
      end else if (CMP_W'(cfg_in_width_ff) > CMP_W'(pris_pkg::MAX_WIDTH)) begin
         w_lim = CMP_W'(pris_pkg::MAX_WIDTH);
      end else begin
         w_lim = CMP_W'(cfg_in_width_ff);
      end
      if (cfg_in_height_ff == '0) begin
         h_lim = CMP_W'(1);
      end else if (CMP_W'(cfg_in_height_ff) > CMP_W'(pris_pkg::ROWS_LIMIT)) begin
         h_lim = CMP_W'(pris_pkg::ROWS_LIMIT);
      end else begin
         h_lim = CMP_W'(cfg_in_height_ff);
      end
      mult = (cfg_mult_ff > 6'(pris_pkg::MAX_COPIES)) ? 6'(pris_pkg::MAX_COPIES) : cfg_mult_ff;

      // a new pass starts at column zero
      reload      = (in_column_ff == '0);
      col_ph_eff  = reload ? '0 : col_phase_ff;
      out_col_eff = reload ? '0 : out_column_ff;

      // row copies for this input row, capped by the remaining output rows
      c_rows = {1'b0, mult} +
               CNT_W'((cfg_divisor_ff != '0 && row_phase_ff == '0) ? 1 : 0);
      room = ({1'b0, cfg_out_height_ff} > out_row_ff) ?
             ({1'b0, cfg_out_height_ff} - out_row_ff) : '0;
      if (reload && !req_tuser) begin
         rows_eff = (room < OC_W'(c_rows)) ? room[CNT_W-1:0] : c_rows;
      end else begin
         rows_eff = rows_left_ff;
      end

      // pixel copies, capped at the output row width
      copies = {1'b0, mult} +
               CNT_W'((cfg_divisor_ff != '0 && col_ph_eff == '0) ? 1 : 0);
      avail = ({1'b0, cfg_out_width_ff} > out_col_eff) ?
              ({1'b0, cfg_out_width_ff} - out_col_eff) : '0;
      if (rows_eff == '0) begin
         n_pix = '0;
      end else begin
         n_pix = (avail < OC_W'(copies)) ? avail[CNT_W-1:0] : copies;
      end
      out_column_in = out_col_eff + OC_W'(n_pix);
      col_phase_in  = next_phase(col_ph_eff, cfg_divisor_ff);

      // defaults: mid row
      end_col      = (CMP_W'(in_column_ff) + CMP_W'(1)) >= w_lim;
      row_end      = 1'b0;
      image_end    = 1'b0;
      rows_after   = rows_eff;
      in_column_in = in_column_ff + COL_W'(1);
      in_row_in    = in_row_ff;
      row_phase_in = row_phase_ff;
      out_row_in   = out_row_ff;
      replaying_in = replaying_ff;
      rows_left_in = rows_eff;

      if (end_col) begin
         in_column_in = '0;
         row_end      = (rows_eff != '0);
         if (row_end) begin
            out_row_in = out_row_ff + OC_W'(1);
         end
         rows_after   = rows_eff - CNT_W'(row_end);
         rows_left_in = rows_after;
         replaying_in = (rows_after != '0);
         if (rows_after == '0) begin
            if ((CMP_W'(in_row_ff) + CMP_W'(1)) >= h_lim) begin
               // image done, counters back to zero
               image_end    = 1'b1;
               in_row_in    = '0;
               out_row_in   = '0;
               row_phase_in = '0;
            end else begin
               in_row_in    = in_row_ff + ROW_W'(1);
               row_phase_in = next_phase(row_phase_ff, cfg_divisor_ff);
            end
         end
      end

      // status-only result when nothing is emitted but a row or the image ends
      if (n_pix != '0) begin
         n_total = n_pix;
      end else begin
         n_total = CNT_W'((row_end || image_end) ? 1 : 0);
      end

      job_in.replay        = req_tuser;
      job_in.pix           = req_tdata;
      job_in.count         = n_pix;
      job_in.row_end       = row_end;
      job_in.pad           = row_end ? cfg_out_width_ff[1:0] : 2'd0;
      job_in.image_end     = image_end;
      job_in.replay_wanted = replaying_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         col_phase_ff  <= '0;
         row_phase_ff  <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
         rows_left_ff  <= '0;
         replaying_ff  <= 1'b0;
      end else if (hit) begin
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         col_phase_ff  <= col_phase_in;
         row_phase_ff  <= row_phase_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
         rows_left_ff  <= rows_left_in;
         replaying_ff  <= replaying_in;
      end
   end

   // ---------------------------------------------------------------- line buffer
   // push writes the column entry, replay reads it; read data holds until the next replay
   always_ff @(posedge clock) begin
      if (hit && !req_tuser) begin
         line_mem[in_column_ff] <= req_tdata;
      end
      if (hit && req_tuser) begin
         rdata_ff <= line_mem[in_column_ff];
      end
   end

   // ---------------------------------------------------------------- job stage
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else if (hit && n_total != '0) begin
         job_valid_ff <= 1'b1;
      end else if (job_adv) begin
         job_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (hit && n_total != '0) begin
         job_ff <= job_in;
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         rem_ff       <= '0;
      end else if (job_adv) begin
         out_valid_ff <= 1'b1;
         rem_ff       <= (job_ff.count == '0) ? '0 : job_ff.count - CNT_W'(1);
      end else if (out_valid_ff && rsp_tready) begin
         if (rem_ff == '0) begin
            out_valid_ff <= 1'b0;
         end else begin
            rem_ff <= rem_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_adv) begin
         out_pix_ff       <= job_ff.replay ? rdata_ff : job_ff.pix;
         out_pvalid_ff    <= (job_ff.count != '0);
         out_row_end_ff   <= job_ff.row_end;
         out_pad_ff       <= job_ff.pad;
         out_image_end_ff <= job_ff.image_end;
         out_rw_ff        <= job_ff.replay_wanted;
      end
   end

   // row end, pad count and image end ride on the final result of an item only; replay_wanted on every result
   assign out_last   = (rem_ff == '0);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_pvalid_ff;
   assign rsp_tlast  = out_last;
   assign rsp_tdata  = {3'b000,
                        out_rw_ff,
                        out_last & out_image_end_ff,
                        out_last ? out_pad_ff : 2'd0,
                        out_last & out_row_end_ff,
                        out_pvalid_ff ? out_pix_ff : 24'd0};

   // ---------------------------------------------------------------- assertions
   a_status_single : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("status-only result is not the last of its item");

   a_pad_with_row_end : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[24] |-> rsp_tdata[26:25] == 2'd0)
      else $error("pad count without row end");

   a_no_job_adv_stall : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !job_adv)
      else $error("job stage advanced into a stalled output");

   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      rem_ff <= CNT_W'(pris_pkg::MAX_COPIES))
      else $error("remaining copies out of range");

   a_replay_rows : assert property (@(posedge clock) disable iff (reset)
      replaying_ff |-> rows_left_ff != '0)
      else $error("replay pass with no rows left");

endmodule

### tb/scaler_result_checker.sv
module scaler_result_checker
   import pris_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // blue[7:0], green[15:8], red[23:16]
   input  logic        req_tuser,   // cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // blue_out, green_out, red_out, row_end, pad_count[1:0],
                                    // image_end, replay_wanted, zero fill
   input  logic        rsp_tuser,   // pixel_valid
   input  logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [17:0] csr_wdata,
   output int          fail_count,
   output int          results_due,
   output logic        replay_due,
   output logic        image_start
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       pixel_valid;
      logic       last;
      logic       row_end;
      logic [1:0] pad_count;
      logic       image_end;
      logic       replay_wanted;
   } scaled_pixel_t;

   localparam int unsigned OC_MASK = (1 << OC_W) - 1;

   scaled_pixel_t pending_pixels[$];

   // shadow of the control registers
   logic [12:0] in_width;
   logic [12:0] in_height;
   logic [5:0]  multiplier;
   logic [15:0] divisor;
   logic [17:0] out_width;
   logic [17:0] out_height;

   // scaler state
   logic [PIX_W-1:0] line_buf [MAX_WIDTH];
   int unsigned col_in, row_in, col_phase, row_phase, col_out, row_out, passes_left;
   bit          replaying;

   int mismatches = 0;
   int queued     = 0;

   assign fail_count  = mismatches;
   assign results_due = queued;
   assign replay_due  = replaying;
   assign image_start = (col_in == 0) && (row_in == 0) && !replaying;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (mismatches < 200)
         $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic compare(input string what, input int unsigned got, input int unsigned want);
      if (got != want)
         report_mismatch(what, got, want);
   endtask

   function automatic int unsigned advance_phase(input int unsigned ph);
      if (divisor == 0 || ph + 1 >= divisor)
         return 0;
      return ph + 1;
   endfunction

   task automatic scale_item(input logic replay, input logic [PIX_W-1:0] pixel);
      int unsigned   w, h, mult, copies, room, rows, pad;
      logic [PIX_W-1:0] px;
      bit            row_done, image_done;
      scaled_pixel_t batch[$];
      scaled_pixel_t r;
      // wrong command for the current pass is dropped
      if (replay != replaying)
         return;
      w    = (in_width == 0) ? 1 : ((in_width > MAX_WIDTH) ? MAX_WIDTH : in_width);
      h    = (in_height == 0) ? 1 : ((in_height > ROWS_LIMIT) ? ROWS_LIMIT : in_height);
      mult = (multiplier > MAX_COPIES) ? MAX_COPIES : multiplier;
      row_done   = 0;
      image_done = 0;
      if (col_in == 0) begin
         col_out   = 0;
         col_phase = 0;
         if (!replay) begin
            rows = mult + ((divisor != 0 && row_phase == 0) ? 1 : 0);
            room = (out_height > row_out) ? out_height - row_out : 0;
            passes_left = (rows < room) ? rows : room;
         end
      end
      if (!replay) begin
         px = pixel;
         line_buf[col_in] = pixel;
      end else begin
         px = line_buf[col_in];
      end
      if (passes_left > 0) begin
         copies = mult + ((divisor != 0 && col_phase == 0) ? 1 : 0);
         for (int i = 0; i < copies; i++) begin
            if (col_out < out_width) begin
               r.blue        = px[7:0];
               r.green       = px[15:8];
               r.red         = px[23:16];
               r.pixel_valid = 1'b1;
               r.last        = 1'b0;
               r.row_end     = 1'b0;
               r.pad_count   = 2'd0;
               r.image_end   = 1'b0;
               r.replay_wanted = 1'b0;
               batch.push_back(r);
               col_out = (col_out + 1) & OC_MASK;
            end
         end
      end
      col_phase = advance_phase(col_phase);
      if (col_in + 1 >= w) begin
         col_in = 0;
         if (passes_left > 0) begin
            row_done = 1;
            row_out  = (row_out + 1) & OC_MASK;
            passes_left--;
         end
         if (passes_left > 0) begin
            replaying = 1;
         end else begin
            replaying = 0;
            if (row_in + 1 >= h) begin
               image_done = 1;
               row_in     = 0;
               row_out    = 0;
               row_phase  = 0;
            end else begin
               row_in++;
               row_phase = advance_phase(row_phase);
            end
         end
      end else begin
         col_in++;
      end
      // row or image status with no pixel rides on an empty result
      if (batch.size() == 0 && (row_done || image_done)) begin
         r = '{default: '0};
         batch.push_back(r);
      end
      if (batch.size() > 0) begin
         pad = (4 - ((int'(out_width) * 3) & 3)) & 3;
         batch[$].last      = 1'b1;
         batch[$].row_end   = row_done;
         batch[$].pad_count = row_done ? pad[1:0] : 2'd0;
         batch[$].image_end = image_done;
      end
      foreach (batch[k]) begin
         batch[k].replay_wanted = replaying;
         pending_pixels.push_back(batch[k]);
      end
   endtask

   task automatic check_result();
      scaled_pixel_t want;
      if (pending_pixels.size() == 0) begin
         report_mismatch("result with nothing pending", rsp_tdata, 0);
         return;
      end
      want = pending_pixels.pop_front();
      compare("blue_out", rsp_tdata[7:0], want.blue);
      compare("green_out", rsp_tdata[15:8], want.green);
      compare("red_out", rsp_tdata[23:16], want.red);
      compare("pixel_valid", rsp_tuser, want.pixel_valid);
      compare("last", rsp_tlast, want.last);
      compare("row_end", rsp_tdata[24], want.row_end);
      compare("pad_count", rsp_tdata[26:25], want.pad_count);
      compare("image_end", rsp_tdata[27], want.image_end);
      compare("replay_wanted", rsp_tdata[28], want.replay_wanted);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         in_width    = 13'd1;
         in_height   = 13'd1;
         multiplier  = 6'd1;
         divisor     = 16'd0;
         out_width   = 18'd1;
         out_height  = 18'd1;
         col_in      = 0;
         row_in      = 0;
         col_phase   = 0;
         row_phase   = 0;
         col_out     = 0;
         row_out     = 0;
         passes_left = 0;
         replaying   = 0;
         pending_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_IN_WIDTH:   in_width   = csr_wdata[12:0];
               REG_IN_HEIGHT:  in_height  = csr_wdata[12:0];
               REG_MULTIPLIER: multiplier = csr_wdata[5:0];
               REG_DIVISOR:    divisor    = csr_wdata[15:0];
               REG_OUT_WIDTH:  out_width  = csr_wdata;
               REG_OUT_HEIGHT: out_height = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            scale_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_result();
      end
      queued = pending_pixels.size();
   end

endmodule

### tb/tb_pixel_replication_image_scaler.sv
module tb_pixel_replication_image_scaler;
   import pris_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // command carried in req_tuser
   localparam logic CMD_PUSH   = 1'b0;
   localparam logic CMD_REPLAY = 1'b1;

   // cycles with no handshake at all before the run is called hung
   localparam int STALL_LIMIT     = 1000;
   // pipeline flush before a register write and before the verdict
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 15;
   localparam int NOISE_PCT       = 10;
   // short runs on the widest and the tallest settings
   localparam int WIDE_ITEMS      = 8;
   localparam int TALL_ITEMS      = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;    // blue[7:0], green[15:8], red[23:16]
   logic        req_tuser  = CMD_PUSH;   // cmd

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // blue_out, green_out, red_out, row_end, pad_count[1:0],
                                    // image_end, replay_wanted, zero fill
   logic        rsp_tuser;          // pixel_valid
   logic        rsp_tlast;          // last

   logic        csr_we    = 1'b0;
   logic [2:0]  csr_index = REG_IN_WIDTH;
   logic [17:0] csr_wdata = '0;

   int          fail_count;
   int          results_due;
   logic        replay_due;
   logic        image_start;

   // stretches with no idling on either side
   bit          steady = 1'b0;
   int          ready_hold = 0;
   int          idle_cycles = 0;
   // last raw in_width written, bounds mid-image width changes
   int unsigned width_now = 1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pixel_replication_image_scaler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predicts and checks every result, reports where the scaler stands
   scaler_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .results_due (results_due),
      .replay_due  (replay_due),
      .image_start (image_start)
   );

   // mostly short pauses, now and then a long one
   function automatic int pause_len();
      int pick;
      pick = $urandom_range(99, 0);
      if (pick < 85)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // result side backpressure, changes only at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold = ready_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!steady && $urandom_range(99, 0) < 20) begin
         ready_hold = pause_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // hang detection: any handshake resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("pixel_replication_image_scaler regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one item on the input channel, with an optional gap in front;
   // called and returning at a falling edge
   task automatic send_item(input logic cmd, input logic [23:0] pixel);
      int gap;
      gap = (!steady && $urandom_range(99, 0) < 30) ? pause_len() : 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= pixel;
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
   endtask

   // follow the pass the scaler is in, with a share of wrong commands mixed in
   task automatic run_items(input int count, input int noise_pct);
      logic cmd;
      repeat (count) begin
         cmd = replay_due ? CMD_REPLAY : CMD_PUSH;
         if ($urandom_range(99, 0) < noise_pct)
            cmd = !cmd;
         send_item(cmd, 24'($urandom()));
      end
   endtask

   // stop sending, let every result come out and the pipeline empty
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (results_due != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[17:0];
      @(negedge clock);
   endtask

   // all six registers, written only once the scaler is idle
   task automatic configure(input int unsigned w, input int unsigned h, input int unsigned m,
                            input int unsigned d, input int unsigned ow,
                            input int unsigned oh);
      quiesce();
      write_reg(REG_IN_WIDTH, w);
      write_reg(REG_IN_HEIGHT, h);
      write_reg(REG_MULTIPLIER, m);
      write_reg(REG_DIVISOR, d);
      write_reg(REG_OUT_WIDTH, ow);
      write_reg(REG_OUT_HEIGHT, oh);
      csr_we    <= 1'b0;
      width_now = w;
   endtask

   initial begin
      int unsigned w, h, m, d, ow, oh;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: one pixel per image, one copy; darkest and brightest pixel
      send_item(CMD_PUSH, 24'h000000);
      send_item(CMD_PUSH, 24'hFFFFFF);
      // replay with none pending is dropped
      send_item(CMD_REPLAY, 24'h5AA55A);

      // 3x2 image, two copies plus one every second pixel and row, width cap hit
      // inside the row so the last column ends the row with a status-only result
      configure(3, 2, 2, 2, 5, 4);
      run_items(3, 0);
      // push while replays are pending is dropped
      send_item(replay_due ? CMD_PUSH : CMD_REPLAY, 24'hC3C3C3);
      run_items(9, 0);

      // most copies per item: 63 plus the extra one on every pixel
      configure(1, 1, MAX_COPIES, 1, 262143, 2);
      run_items(2, 0);

      // zero input width and height act as one, no copies at all: only the image end status
      configure(0, 0, 0, 0, 0, 262143);
      run_items(1, 0);

      // no output rows left: rows are buffered but never emitted
      configure(2, 1, 3, 0, 7, 0);
      run_items(2, 0);

      // random settings and content; width only grows at the start of an image
      // so a replay never reads a line buffer entry that was never written
      repeat (RANDOM_PHASES) begin
         m  = ($urandom_range(7, 0) == 0) ? MAX_COPIES : $urandom_range(4, 0);
         d  = ($urandom_range(7, 0) == 0) ? 65535 : $urandom_range(3, 0);
         ow = ($urandom_range(7, 0) == 0) ? 262143 : $urandom_range(20, 0);
         if (m == MAX_COPIES)
            oh = $urandom_range(3, 0);
         else
            oh = ($urandom_range(7, 0) == 0) ? 262143 : $urandom_range(12, 0);
         h  = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(4, 1);
         if (image_start)
            w = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(5, 1);
         else
            w = $urandom_range((width_now == 0) ? 1 : width_now, 1);
         configure(w, h, m, d, ow, oh);
         steady = ($urandom_range(3, 0) == 0);
         run_items(ITEMS_PER_PHASE, NOISE_PCT);
      end
      steady = 1'b0;

      // close the open image before the widest settings
      while (!image_start)
         send_item(replay_due ? CMD_REPLAY : CMD_PUSH, 24'($urandom()));

      // width above the buffer depth acts as the full depth: the row stays open
      // and the output cap stops the copies after two pixels
      configure(8191, 1, 1, 0, 2, 1);
      run_items(WIDE_ITEMS, 0);

      // tallest image: the open wide row ends at once, later rows get no copies
      configure(1, 8191, 0, 65535, 262143, 262143);
      run_items(TALL_ITEMS, 0);

      quiesce();
      if (fail_count == 0 && results_due == 0)
         $display("pixel_replication_image_scaler regression: pass");
      else
         $display("pixel_replication_image_scaler regression: fail");
      $finish;
   end

endmodule
